/* sv/rfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODED_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_SHORT = 3'd3;
    localparam logic [2:0] ST_CRC = 3'd4;
    localparam logic [2:0] ST_RAWLEN = 3'd5;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    typedef enum logic [2:0] {
        PH_CONTROL = 3'b001,
        PH_RUN = 3'b010,
        PH_LITERAL = 3'b100
    } t_phase;

    typedef struct packed {
        logic compressed_mode;
        logic [LEN_W-1:0] decoded_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] repeat_count;
        logic last;
        logic [2:0] pre_status;
    } t_job;

endpackage

`default_nettype wire

/* sv/rle_field_decoder_crc_check_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Run-length field decoder with a CRC-32 check over the decoded bytes. The front end takes
// one encoded byte per cycle while its four-entry job queue has room; control bytes only
// update the token state and leave no job unless they are the last byte. The back end
// folds the decoded bytes into the CRC one byte per cycle and takes a new job only as
// it finishes the one before, so a run holds it longer. Sustained throughput is set by
// that CRC unit; the queue and the output register let the input keep flowing during
// long runs and stalls. Results with done set carry the field status; the decoder state
// returns to reset after every last byte; the configuration registers keep their values.
module rle_field_decoder_crc_check_unit #(
    parameter int MAX_FIELD_BYTES = 67108864
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_cfg_we,
    input wire logic [rfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [rfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire logic i_in_valid,
    output logic o_in_stall,
    input wire logic [7:0] i_in_byte,
    input wire logic i_last_byte,
    output logic o_out_valid,
    input wire logic i_out_stall,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_repeat_count,
    output logic o_done_res,
    output logic [2:0] o_status
);
    import rfd_pkg::*;

    logic r_compressed_mode;
    logic [LEN_W-1:0] r_decoded_length;
    logic [31:0] r_expected_crc;

    t_cfg cfg;
    t_job push_job, head_job;
    logic q_push, q_pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed_mode <= 1'b0;
            r_decoded_length <= '0;
            r_expected_crc <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COMPRESSED_MODE: r_compressed_mode <= i_cfg_data[0];
                CFG_DECODED_LENGTH: r_decoded_length <= i_cfg_data[LEN_W-1:0];
                CFG_EXPECTED_CRC: r_expected_crc <= i_cfg_data[31:0];
                default: r_compressed_mode <= r_compressed_mode;
            endcase
        end
    end

    assign cfg.compressed_mode = r_compressed_mode;
    assign cfg.decoded_length = r_decoded_length;

    rfd_front #(
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(cfg),
        .i_in_valid(i_in_valid),
        .i_in_byte(i_in_byte),
        .i_last_byte(i_last_byte),
        .i_q_full(q_full),
        .o_in_stall(o_in_stall),
        .o_push(q_push),
        .o_job(push_job)
    );

    rfd_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(q_push),
        .i_job(push_job),
        .i_pop(q_pop),
        .o_full(q_full),
        .o_empty(q_empty),
        .o_job(head_job)
    );

    rfd_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job(head_job),
        .i_q_empty(q_empty),
        .i_expected_crc(r_expected_crc),
        .i_out_stall(i_out_stall),
        .o_pop(q_pop),
        .o_out_valid(o_out_valid),
        .o_data_byte(o_data_byte),
        .o_repeat_count(o_repeat_count),
        .o_done_res(o_done_res),
        .o_status(o_status)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

    a_data_result_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_repeat_count != 8'd0 && o_status == ST_OK))
        else $error("intermediate result without data or with a status");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_repeat_count <= 8'd130))
        else $error("repeat count out of range");

endmodule

`default_nettype wire

/* sv/rfd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rfd_front #(
    parameter int MAX_FIELD_BYTES = 67108864
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire rfd_pkg::t_cfg i_cfg,
    input wire logic i_in_valid,
    input wire logic [7:0] i_in_byte,
    input wire logic i_last_byte,
    input wire logic i_q_full,
    output logic o_in_stall,
    output logic o_push,
    output rfd_pkg::t_job o_job
);
    import rfd_pkg::*;

    t_phase r_phase, n_phase;
    logic [7:0] r_literal_left, n_literal_left;
    logic [7:0] r_pending_run, n_pending_run;
    logic [LEN_W-1:0] r_count, n_count;
    logic [2:0] r_err, n_err;

    logic accept;
    logic [LEN_W-1:0] lim;
    logic [7:0] run_len, lit_len, tok_len;
    logic tok_fits, raw_fits;
    logic [7:0] emit_val, emit_cnt;
    logic [7:0] lit_dec;
    logic [2:0] end_err;

    assign accept = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    assign lim = ({5'b0, i_cfg.decoded_length} > 32'(MAX_FIELD_BYTES)) ?
                 LEN_W'(MAX_FIELD_BYTES) : i_cfg.decoded_length;

    assign run_len = {1'b0, i_in_byte[6:0]} + 8'd3;
    assign lit_len = {1'b0, i_in_byte[6:0]} + 8'd1;
    assign tok_len = i_in_byte[7] ? run_len : lit_len;
    assign tok_fits = ({1'b0, r_count} + {20'b0, tok_len}) <= {1'b0, lim};
    assign raw_fits = ({1'b0, r_count} + 28'd1) <= {1'b0, lim};
    assign lit_dec = r_literal_left - 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_literal_left = r_literal_left;
        n_pending_run = r_pending_run;
        n_err = r_err;
        emit_val = 8'd0;
        emit_cnt = 8'd0;
        if (r_err == ST_OK) begin
            if (!i_cfg.compressed_mode) begin
                if (!raw_fits) begin
                    n_err = ST_RAWLEN;
                end else begin
                    emit_val = i_in_byte;
                    emit_cnt = 8'd1;
                end
            end else begin
                case (r_phase)
                    PH_CONTROL: begin
                        if (i_last_byte) begin
                            n_err = ST_TRUNCATED;
                        end else if (!tok_fits) begin
                            n_err = ST_OVERFLOW;
                        end else if (i_in_byte[7]) begin
                            n_pending_run = run_len;
                            n_phase = PH_RUN;
                        end else begin
                            n_literal_left = lit_len;
                            n_phase = PH_LITERAL;
                        end
                    end
                    PH_RUN: begin
                        emit_val = i_in_byte;
                        emit_cnt = r_pending_run;
                        n_pending_run = 8'd0;
                        n_phase = PH_CONTROL;
                    end
                    PH_LITERAL: begin
                        emit_val = i_in_byte;
                        emit_cnt = 8'd1;
                        n_literal_left = lit_dec;
                        if (lit_dec == 8'd0) begin
                            n_phase = PH_CONTROL;
                        end
                    end
                    default: begin
                        n_phase = PH_CONTROL;
                    end
                endcase
            end
        end
        n_count = r_count + LEN_W'(emit_cnt);

        end_err = n_err;
        if (n_err == ST_OK) begin
            if (i_cfg.compressed_mode) begin
                if (n_phase != PH_CONTROL) begin
                    end_err = ST_TRUNCATED;
                end else if (n_count != i_cfg.decoded_length) begin
                    end_err = ST_SHORT;
                end
            end else if (n_count != i_cfg.decoded_length) begin
                end_err = ST_RAWLEN;
            end
        end
    end

    assign o_push = accept && ((emit_cnt != 8'd0) || i_last_byte);
    assign o_job.data_byte = emit_val;
    assign o_job.repeat_count = emit_cnt;
    assign o_job.last = i_last_byte;
    assign o_job.pre_status = i_last_byte ? end_err : ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CONTROL;
            r_literal_left <= 8'd0;
            r_pending_run <= 8'd0;
            r_count <= '0;
            r_err <= ST_OK;
        end else if (accept) begin
            if (i_last_byte) begin
                r_phase <= PH_CONTROL;
                r_literal_left <= 8'd0;
                r_pending_run <= 8'd0;
                r_count <= '0;
                r_err <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_literal_left <= n_literal_left;
                r_pending_run <= n_pending_run;
                r_count <= n_count;
                r_err <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/rfd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module rfd_queue (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_push,
    input wire rfd_pkg::t_job i_job,
    input wire logic i_pop,
    output logic o_full,
    output logic o_empty,
    output rfd_pkg::t_job o_job
);
    import rfd_pkg::*;

    t_job r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0] r_cnt;

    assign o_full = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10: r_cnt <= r_cnt + 1'b1;
                2'b01: r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/rfd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rfd_back (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire rfd_pkg::t_job i_job,
    input wire logic i_q_empty,
    input wire logic [31:0] i_expected_crc,
    input wire logic i_out_stall,
    output logic o_pop,
    output logic o_out_valid,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_repeat_count,
    output logic o_done_res,
    output logic [2:0] o_status
);
    import rfd_pkg::*;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    logic r_act;
    t_job r_job;
    logic [7:0] r_left;
    logic [31:0] r_crc;
    logic r_out_valid;
    logic [7:0] r_data_byte, r_repeat_count;
    logic r_done_res;
    logic [2:0] r_status;

    logic slot_free, finish, stepping;
    logic [2:0] fin_status;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign stepping = r_act && (r_left != 8'd0);
    assign finish = r_act && (r_left == 8'd0) && slot_free;
    assign o_pop = !i_q_empty && (!r_act || finish);

    assign fin_status = (r_job.pre_status == ST_OK && ~r_crc != i_expected_crc) ?
                        ST_CRC : r_job.pre_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_left <= 8'd0;
            r_crc <= 32'hFFFFFFFF;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
                r_left <= i_job.repeat_count;
            end else begin
                if (finish) begin
                    r_act <= 1'b0;
                end
                if (stepping) begin
                    r_left <= r_left - 8'd1;
                end
            end
            if (finish && r_job.last) begin
                r_crc <= 32'hFFFFFFFF;
            end else if (stepping) begin
                r_crc <= crc_byte(r_crc, r_job.data_byte);
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (finish) begin
            r_data_byte <= r_job.data_byte;
            r_repeat_count <= r_job.repeat_count;
            r_done_res <= r_job.last;
            r_status <= r_job.last ? fin_status : ST_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data_byte;
    assign o_repeat_count = r_repeat_count;
    assign o_done_res = r_done_res;
    assign o_status = r_status;

endmodule

`default_nettype wire
